[hw/rtl/fpp_pkg.sv]
`timescale 1ns / 1ps
package fpp_pkg;
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_RED    = 6'b000010,
		ST_SQR    = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_NEXT   = 6'b010000,
		ST_DONE   = 6'b100000
	} fpp_state_t;
	localparam int unsigned BASE_W = 16;
	localparam logic [BASE_W-1:0] BASE_RESET = 16'd3;
endpackage

[hw/rtl/fpp_mulmod.sv]
`timescale 1ns / 1ps
module fpp_mulmod import fpp_pkg::*; #(
	parameter int WIDTH = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] n,
	output logic             done,
	output logic [WIDTH-1:0] r
);
	localparam int CW = $clog2(WIDTH);
	logic [WIDTH-1:0] acc_q, b_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [WIDTH:0] dbl, dbl_red, add_s;
	logic [WIDTH-1:0] d_res;
	// One step: double the residue, then add a when the next bit of b is set.
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
		d_res = dbl_red[WIDTH-1:0];
		add_s = {1'b0, d_res} + (b_q[WIDTH-1] ? {1'b0, a} : '0);
		if (add_s >= {1'b0, n}) add_s = add_s - {1'b0, n};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= add_s[WIDTH-1:0];
			b_q   <= {b_q[WIDTH-2:0], 1'b0};
		end
	end
	assign r = acc_q;
endmodule

[hw/rtl/fermat_probable_prime_test_core.sv]
`timescale 1ns / 1ps
// Fermat probable-prime test. One request carries a candidate n (low and high
// 64-bit halves, bits at or above WIDTH ignored); the core computes
// fermat_base^(n-1) mod n by left-to-right square-and-multiply and answers
// probable_prime when the residue is 1. Candidates below two return
// invalid_input with probable_prime clear, going straight to the done state. All
// modular products run on one bit-serial multiply unit: one base reduction,
// then per exponent bit a square and, when the bit is set, a multiply. The
// core accepts no request while one is in progress; a finished result waits
// in the output register. The user must write fermat_base only while the
// core is idle; the core itself does not enforce this.
module fermat_probable_prime_test_core import fpp_pkg::*; #(
	parameter int WIDTH = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data,       // fermat_base
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // number_low [63:0], number_high [127:64]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [7:0]   m_axis_tdata    // probable_prime [0], invalid_input [1], zero
);
	localparam int CW = $clog2(WIDTH);
	fpp_state_t state_q;
	logic [BASE_W-1:0] base_q;
	logic [WIDTH-1:0] n_q, e_q, b_q, z_q, ma, mb, mr;
	logic [CW-1:0] bit_q;
	logic mstart, mdone, pp_q, inv_q, ov_q;
	logic [WIDTH-1:0] n_in;

	assign n_in = s_axis_tdata[WIDTH-1:0];
	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE) && !ov_q;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {6'd0, inv_q, pp_q};

	// Operand selection for the shared unit; the base reduction is base*1 mod n.
	always_comb begin
		ma = z_q;
		mb = z_q;
		case (state_q)
			ST_RED:  begin ma = WIDTH'(1); mb = WIDTH'(base_q); end
			ST_MUL:  begin ma = b_q; mb = z_q; end
			default: begin ma = z_q; mb = z_q; end
		endcase
	end

	fpp_mulmod #(.WIDTH(WIDTH)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb), .n(n_q),
		.done(mdone), .r(mr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q  <= BASE_RESET;
			ov_q    <= 1'b0;
			mstart  <= 1'b0;
			bit_q   <= '0;
		end else begin
			mstart <= 1'b0;
			if (cfg_valid) base_q <= cfg_data;
			if (ov_q && m_axis_tready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					if (n_in < WIDTH'(2)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RED;
						mstart  <= 1'b1;
					end
					bit_q <= CW'(WIDTH - 1);
				end
				ST_RED: if (mdone) begin
					state_q <= ST_SQR;
					mstart  <= 1'b1;
				end
				ST_SQR: if (mdone) begin
					if (e_q[bit_q]) begin
						state_q <= ST_MUL;
						mstart  <= 1'b1;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_MUL: if (mdone) state_q <= ST_NEXT;
				ST_NEXT: begin
					if (bit_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= ST_SQR;
						mstart  <= 1'b1;
					end
				end
				ST_DONE: begin
					ov_q    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
				n_q   <= n_in;
				e_q   <= n_in - 1'b1;
				inv_q <= n_in < WIDTH'(2);
				z_q   <= WIDTH'(1);
			end
			ST_RED:  if (mdone) b_q <= mr;
			ST_SQR:  if (mdone) z_q <= mr;
			ST_MUL:  if (mdone) z_q <= mr;
			ST_DONE: pp_q <= !inv_q && (z_q == WIDTH'(1));
			default: ;
		endcase
	end
endmodule

[hw/rtl/fpp_checker.sv]
`timescale 1ns / 1ps
module fpp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);
	// A result never claims both prime and invalid.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1])) else $error("prime and invalid");
	// No new request is taken while a result waits.
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept during pending result");
	// After an accepted request the core is busy next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped");
endmodule

bind fermat_probable_prime_test_core fpp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

[test/tb_fermat_probable_prime_test_core.sv]
`timescale 1ns / 1ps
module tb_fermat_probable_prime_test_core;
	import fpp_pkg::*;

	localparam int WIDTH = 128;
	localparam int IDLE_LIMIT = 500000;
	localparam int LONG_HOLD = 150000;

	typedef struct packed {
		logic prime;
		logic invalid;
	} verdict_t;

	class primality_scoreboard;
		verdict_t pending_verdicts[$];
		logic [BASE_W-1:0] base;
		int errors;

		function new();
			base = BASE_RESET;
			errors = 0;
		endfunction

		// Modular exponentiation over 256-bit intermediates; the candidate is
		// masked to WIDTH bits first.
		function verdict_t fermat_verdict(logic [127:0] cand);
			logic [255:0] n, b, z;
			logic [127:0] e;
			verdict_t v;
			n = 256'(cand);
			if (WIDTH < 128)
				n = n & ((256'd1 << WIDTH) - 1);
			if (n < 2) begin
				v.prime = 1'b0;
				v.invalid = 1'b1;
				return v;
			end
			e = n[127:0] - 1;
			b = 256'(base) % n;
			z = 1;
			for (int i = WIDTH - 1; i >= 0; i--) begin
				z = (z * z) % n;
				if (e[i])
					z = (z * b) % n;
			end
			v.prime = (z == 1);
			v.invalid = 1'b0;
			return v;
		endfunction

		function void note_candidate(logic [127:0] cand);
			pending_verdicts = {pending_verdicts, fermat_verdict(cand)};
		endfunction

		function void check_verdict(logic [7:0] data);
			verdict_t exp_v;
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result 0x%02h", data);
				errors++;
				return;
			end
			exp_v = pending_verdicts.pop_front();
			if (data[0] !== exp_v.prime) begin
				$error("probable_prime expected %0d actual %0d", exp_v.prime, data[0]);
				errors++;
			end
			if (data[1] !== exp_v.invalid) begin
				$error("invalid_input expected %0d actual %0d", exp_v.invalid, data[1]);
				errors++;
			end
			if (data[7:2] !== 6'd0) begin
				$error("padding expected 0 actual 0x%02h", data[7:2]);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [7:0]   m_axis_tdata;

	primality_scoreboard sb = new();
	logic long_hold = 1'b0;
	int idle_cycles = 0;

	fermat_probable_prime_test_core #(.WIDTH(WIDTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Any handshake counts as progress; a long silence ends the run.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Result side: random stalls per result, plus one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 8);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			sb.check_verdict(m_axis_tdata);
		end
	end

	task automatic send_candidate(logic [127:0] cand);
		int gap;
		gap = $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= cand;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		sb.note_candidate(cand);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
	endtask

	// Let every outstanding verdict arrive, then give the core time to settle
	// before touching the base register.
	task automatic drain();
		stop_sending();
		while (sb.pending_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_base(logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		sb.base = value;
	endtask

	function automatic logic [127:0] rand_candidate();
		logic [127:0] mersenne[5];
		int small_primes[8];
		int p, q;
		mersenne = '{(128'd1 << 61) - 1, (128'd1 << 89) - 1, (128'd1 << 107) - 1,
			(128'd1 << 127) - 1, 128'd18446744073709551557};
		small_primes = '{5, 7, 11, 13, 65521, 65537, 104729, 2147483647};
		case ($urandom_range(0, 9))
			0, 1: return 128'(small_primes[$urandom_range(0, 7)]);
			2: return mersenne[$urandom_range(0, 4)];
			3: return 128'($urandom_range(2, 65535) | 1);
			4, 5: return {$urandom, $urandom, $urandom, $urandom};
			6: return {64'd0, $urandom, $urandom};
			7: return 128'($urandom_range(0, 1));
			8: begin
				p = small_primes[$urandom_range(0, 5)];
				q = small_primes[$urandom_range(0, 5)];
				return 128'(p) * 128'(q);
			end
			default: begin
				case ($urandom_range(0, 2))
					0: return 128'd561;
					1: return 128'd1105;
					default: return 128'd1729;
				endcase
			end
		endcase
	endfunction

	task automatic random_phase(int count);
		repeat (count) send_candidate(rand_candidate());
	endtask

	initial begin
		logic [15:0] bases[5];
		bases = '{16'd65535, 16'd0, 16'd1, 16'd3, 16'd7};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset base, then base two.
		send_candidate(128'd0);
		send_candidate(128'd1);
		send_candidate(128'd2);
		send_candidate(128'd3);        // base equals n, residue is zero
		send_candidate(128'd9);        // n divides base squared
		send_candidate(128'd561);      // Carmichael number sharing a factor with 3
		send_candidate(128'd65537);
		send_candidate({64'd1, 64'd0});
		send_candidate({64'd0, {64{1'b1}}});
		send_candidate({128{1'b1}});
		send_candidate((128'd1 << 127) - 1);
		send_candidate({64'd1, 64'd1});
		drain();
		write_base(16'd2);
		send_candidate(128'd2);        // even base reduces to zero
		send_candidate(128'd341);      // base-two pseudoprime
		send_candidate(128'd561);
		send_candidate(128'd4);
		send_candidate((128'd1 << 89) - 1);
		send_candidate({$urandom, $urandom, $urandom, $urandom});
		random_phase(10);
		drain();

		// Random requests per base; at the first the receiver holds off meanwhile.
		foreach (bases[k]) begin
			write_base(bases[k]);
			if (k == 0) begin
				long_hold = 1'b1;
				random_phase(4);
				drain();
			end
			random_phase(14);
			drain();
		end

		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
